// ===== design/pcss_pkg.sv =====
// Package for the polyphonic chord saw synth unit.
// Holds sizes, state, mode and action codes, register indexes and the pitch table.
// No dependencies.
package pcss_pkg;

    localparam int VOICE_COUNT   = 8;
    localparam int PARTIAL_COUNT = 3;
    localparam int PHASE_BITS    = 24;
    localparam int RATE_HZ       = 16000;
    localparam int SLOT_COUNT    = VOICE_COUNT * PARTIAL_COUNT;
    localparam int VOICE_W       = $clog2(VOICE_COUNT);
    localparam int PART_W        = $clog2(PARTIAL_COUNT);
    localparam int SLOT_W        = $clog2(SLOT_COUNT);
    localparam int BUSY_W        = $clog2(VOICE_COUNT + 1);
    localparam int RAM_W         = 2 * PHASE_BITS;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_ON  = 2'd1,
        MODE_REL = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_ATTACK_LENGTH = 3'd0,
        REG_ATTACK_STEP   = 3'd1,
        REG_RELEASE_STEP  = 3'd2,
        REG_ROOT_WEIGHT   = 3'd3,
        REG_SECOND_WEIGHT = 3'd4,
        REG_THIRD_WEIGHT  = 3'd5,
        REG_MASTER_GAIN   = 3'd6,
        REG_SMOOTHING     = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_VOICE,
        S_MUL1,
        S_MUL2,
        S_GAIN,
        S_LP,
        S_PUSH
    } state_t;

    typedef logic [PHASE_BITS-1:0] pitch_rom_t [128];

    localparam logic [31:0] BASE_FREQ_Q16 [12] = '{
        32'd535809, 32'd567670, 32'd601425, 32'd637188, 32'd675077, 32'd715219,
        32'd757749, 32'd802807, 32'd850544, 32'd901120, 32'd954703, 32'd1011473
    };

    // increment = floor(f * 2^PHASE_BITS / RATE_HZ) >> 16
    function automatic pitch_rom_t build_pitch_rom();
        pitch_rom_t  rom;
        logic [63:0] f;
        logic [63:0] x;
        for (int k = 0; k < 128; k++)
        begin
            f = 64'(BASE_FREQ_Q16[k % 12]) << (k / 12);
            x = ((f / RATE_HZ) << PHASE_BITS)
                + (((f % RATE_HZ) << PHASE_BITS) / RATE_HZ);
            rom[k] = PHASE_BITS'(x >> 16);
        end
        return rom;
    endfunction

    localparam pitch_rom_t PITCH_ROM = build_pitch_rom();

endpackage

// ===== design/polyphonic_chord_saw_synth_unit.sv =====
// Top level of the polyphonic chord saw synth unit.
// Uses pcss_pkg, pcss_ram and pcss_mul.
//
// Eight voices of three saw partials each. Input items arrive on s_*; a
// tick item yields one sample item on m_*, note items yield nothing. One
// shared multiplier is stepped by a sequencer: a note-off is handled in
// S_IDLE; a note-on that takes a free voice loads the partial increments
// from the pitch table in S_LOAD; a tick steps S_VOICE per voice, S_MUL1
// and S_MUL2 (two multiplies) per partial of a sounding voice through the
// partial phase RAM, then S_GAIN, S_LP and S_PUSH; it waits in S_PUSH while
// the previous sample item is unaccepted. s_tready is low while an item is in work.
module polyphonic_chord_saw_synth_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // note[6:0], first_interval[11:7],
                                   // second_interval[16:12], third_interval[21:17]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample_out[16:0], voices_busy[20:17]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NV = pcss_pkg::VOICE_COUNT;
    localparam int NP = pcss_pkg::PARTIAL_COUNT;
    localparam int PB = pcss_pkg::PHASE_BITS;
    localparam int VW = pcss_pkg::VOICE_W;
    localparam int PW = pcss_pkg::PART_W;
    localparam int SW = pcss_pkg::SLOT_W;

    pcss_pkg::state_t state_reg, state_next;

    logic [11:0] attack_length_reg;
    logic [15:0] attack_step_reg, release_step_reg;
    logic [15:0] weight_reg [3];
    logic [15:0] master_gain_reg, smoothing_reg;

    logic [6:0]         voice_key_reg   [NV];
    pcss_pkg::mode_t    voice_mode_reg  [NV];
    logic [11:0]        voice_count_reg [NV];
    logic [15:0]        voice_level_reg [NV];

    logic [VW-1:0]        v_reg;
    logic [PW-1:0]        p_reg;
    logic [SW-1:0]        addr_reg;
    logic [6:0]           note_reg;
    logic [4:0]           iv_reg [3];
    logic signed [15:0]   t_reg;
    logic signed [21:0]   sum_reg;
    logic signed [21:0]   raw_reg;
    logic signed [16:0]   lp_reg;
    logic [3:0]           busy_reg;
    logic [23:0]          m_tdata_reg;
    logic                 m_tvalid_reg;

    logic                 ram_we;
    logic [SW-1:0]        ram_waddr, ram_raddr;
    logic [2*PB-1:0]      ram_wdata, ram_rdata;
    logic signed [25:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [43:0]   mul_p;

    logic                 accept;
    logic                 hit;
    logic                 found;
    logic [VW-1:0]        free_v;
    logic [7:0]           key_sum;
    logic [6:0]           key_clamp;
    logic [4:0]           cur_iv;
    logic [15:0]          cur_weight;
    logic signed [15:0]   saw;
    logic signed [22:0]   diff;
    logic signed [23:0]   lp_sum;
    logic [3:0]           busy_cnt;
    logic [16:0]          lv_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == pcss_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    pcss_ram #(.WIDTH(2 * PB), .DEPTH(pcss_pkg::SLOT_COUNT)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcss_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    always_comb
    begin
        hit    = 1'b0;
        found  = 1'b0;
        free_v = '0;
        for (int v = 0; v < NV; v++)
        begin
            if (voice_mode_reg[v] != pcss_pkg::MODE_OFF && voice_key_reg[v] == s_tdata[6:0])
            begin
                hit = 1'b1;
            end
            if (!found && voice_mode_reg[v] == pcss_pkg::MODE_OFF)
            begin
                found  = 1'b1;
                free_v = VW'(v);
            end
        end
    end

    always_comb
    begin
        busy_cnt = '0;
        for (int v = 0; v < NV; v++)
        begin
            busy_cnt = busy_cnt + 4'(voice_mode_reg[v] != pcss_pkg::MODE_OFF);
        end
    end

    always_comb
    begin
        cur_iv     = (p_reg < PW'(3)) ? iv_reg[p_reg] : 5'd0;
        cur_weight = (p_reg < PW'(3)) ? weight_reg[p_reg] : 16'd0;
        key_sum    = {1'b0, note_reg} + {3'b0, cur_iv};
        key_clamp  = key_sum[7] ? 7'd127 : key_sum[6:0];
        saw        = {~ram_rdata[PB-1], ram_rdata[PB-2:PB-16]};
        diff       = 23'(raw_reg) - 23'(lp_reg);
        lp_sum     = 24'(lp_reg) + 24'($signed(mul_p[38:16]));
        lv_sum     = {1'b0, voice_level_reg[v_reg]} + {1'b0, attack_step_reg};
    end

    always_comb
    begin
        mul_a = 26'(saw);
        mul_b = 18'({2'b0, cur_weight});
        case (state_reg)
            pcss_pkg::S_MUL2:
            begin
                mul_a = 26'(t_reg);
                mul_b = 18'({2'b0, voice_level_reg[v_reg]});
            end
            pcss_pkg::S_GAIN:
            begin
                mul_a = 26'(sum_reg);
                mul_b = 18'({2'b0, master_gain_reg});
            end
            pcss_pkg::S_LP:
            begin
                mul_a = 26'(diff);
                mul_b = 18'({2'b0, smoothing_reg});
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {ram_rdata[2*PB-1:PB], ram_rdata[PB-1:0] + ram_rdata[2*PB-1:PB]};
        ram_raddr = addr_reg;
        case (state_reg)
            pcss_pkg::S_LOAD:
            begin
                ram_we    = 1'b1;
                ram_wdata = {pcss_pkg::PITCH_ROM[key_clamp], {PB{1'b0}}};
            end
            pcss_pkg::S_MUL1:
            begin
                ram_we = 1'b1;
            end
            pcss_pkg::S_MUL2:
            begin
                ram_raddr = addr_reg + SW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcss_pkg::S_IDLE:
            begin
                if (accept && s_tuser == pcss_pkg::ACT_ON && !hit && found)
                begin
                    state_next = pcss_pkg::S_LOAD;
                end
                else if (accept && s_tuser == pcss_pkg::ACT_TICK)
                begin
                    state_next = pcss_pkg::S_VOICE;
                end
            end
            pcss_pkg::S_LOAD:
            begin
                if (p_reg == PW'(NP - 1))
                begin
                    state_next = pcss_pkg::S_IDLE;
                end
            end
            pcss_pkg::S_VOICE:
            begin
                if (voice_mode_reg[v_reg] != pcss_pkg::MODE_OFF)
                begin
                    state_next = pcss_pkg::S_MUL1;
                end
                else if (v_reg == VW'(NV - 1))
                begin
                    state_next = pcss_pkg::S_GAIN;
                end
            end
            pcss_pkg::S_MUL1:
            begin
                state_next = pcss_pkg::S_MUL2;
            end
            pcss_pkg::S_MUL2:
            begin
                if (p_reg != PW'(NP - 1))
                begin
                    state_next = pcss_pkg::S_MUL1;
                end
                else if (v_reg == VW'(NV - 1))
                begin
                    state_next = pcss_pkg::S_GAIN;
                end
                else
                begin
                    state_next = pcss_pkg::S_VOICE;
                end
            end
            pcss_pkg::S_GAIN:
            begin
                state_next = pcss_pkg::S_LP;
            end
            pcss_pkg::S_LP:
            begin
                state_next = pcss_pkg::S_PUSH;
            end
            pcss_pkg::S_PUSH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = pcss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pcss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcss_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_length_reg <= 12'd320;
            attack_step_reg   <= 16'd102;
            release_step_reg  <= 16'd41;
            weight_reg[0]     <= 16'd39322;
            weight_reg[1]     <= 16'd16384;
            weight_reg[2]     <= 16'd9830;
            master_gain_reg   <= 16'd16384;
            smoothing_reg     <= 16'd13107;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcss_pkg::REG_ATTACK_LENGTH: attack_length_reg <= cfg_data[11:0];
                pcss_pkg::REG_ATTACK_STEP:   attack_step_reg   <= cfg_data;
                pcss_pkg::REG_RELEASE_STEP:  release_step_reg  <= cfg_data;
                pcss_pkg::REG_ROOT_WEIGHT:   weight_reg[0]     <= cfg_data;
                pcss_pkg::REG_SECOND_WEIGHT: weight_reg[1]     <= cfg_data;
                pcss_pkg::REG_THIRD_WEIGHT:  weight_reg[2]     <= cfg_data;
                pcss_pkg::REG_MASTER_GAIN:   master_gain_reg   <= cfg_data;
                pcss_pkg::REG_SMOOTHING:     smoothing_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NV; v++)
            begin
                voice_key_reg[v]   <= '0;
                voice_mode_reg[v]  <= pcss_pkg::MODE_OFF;
                voice_count_reg[v] <= '0;
                voice_level_reg[v] <= '0;
            end
            v_reg        <= '0;
            p_reg        <= '0;
            addr_reg     <= '0;
            sum_reg      <= '0;
            lp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == pcss_pkg::S_PUSH && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                pcss_pkg::S_IDLE:
                begin
                    v_reg    <= '0;
                    p_reg    <= '0;
                    addr_reg <= '0;
                    sum_reg  <= '0;
                    note_reg <= s_tdata[6:0];
                    iv_reg[0] <= s_tdata[11:7];
                    iv_reg[1] <= s_tdata[16:12];
                    iv_reg[2] <= s_tdata[21:17];
                    if (accept && s_tuser == pcss_pkg::ACT_ON && !hit && found)
                    begin
                        voice_key_reg[free_v]   <= s_tdata[6:0];
                        voice_mode_reg[free_v]  <= pcss_pkg::MODE_ON;
                        voice_count_reg[free_v] <= '0;
                        voice_level_reg[free_v] <= '0;
                        addr_reg <= SW'(free_v) * SW'(NP);
                    end
                    if (accept && s_tuser == pcss_pkg::ACT_OFF)
                    begin
                        for (int v = 0; v < NV; v++)
                        begin
                            if (voice_mode_reg[v] == pcss_pkg::MODE_ON
                                && voice_key_reg[v] == s_tdata[6:0])
                            begin
                                voice_mode_reg[v] <= pcss_pkg::MODE_REL;
                            end
                        end
                    end
                end
                pcss_pkg::S_LOAD:
                begin
                    p_reg    <= p_reg + PW'(1);
                    addr_reg <= addr_reg + SW'(1);
                end
                pcss_pkg::S_VOICE:
                begin
                    p_reg <= '0;
                    case (voice_mode_reg[v_reg])
                        pcss_pkg::MODE_OFF:
                        begin
                            v_reg    <= v_reg + VW'(1);
                            addr_reg <= addr_reg + SW'(NP);
                        end
                        pcss_pkg::MODE_ON:
                        begin
                            if (voice_count_reg[v_reg] < attack_length_reg)
                            begin
                                voice_level_reg[v_reg] <= (lv_sum > 17'd32768)
                                                          ? 16'd32768 : lv_sum[15:0];
                                voice_count_reg[v_reg] <= voice_count_reg[v_reg] + 12'd1;
                            end
                        end
                        default:
                        begin
                            if (voice_level_reg[v_reg] <= release_step_reg)
                            begin
                                voice_level_reg[v_reg] <= '0;
                                voice_mode_reg[v_reg]  <= pcss_pkg::MODE_OFF;
                            end
                            else
                            begin
                                voice_level_reg[v_reg] <= voice_level_reg[v_reg]
                                                          - release_step_reg;
                            end
                        end
                    endcase
                end
                pcss_pkg::S_MUL1:
                begin
                    t_reg <= mul_p[31:16];
                end
                pcss_pkg::S_MUL2:
                begin
                    sum_reg  <= sum_reg + 22'($signed(mul_p[31:15]));
                    addr_reg <= addr_reg + SW'(1);
                    if (p_reg == PW'(NP - 1))
                    begin
                        p_reg <= '0;
                        v_reg <= v_reg + VW'(1);
                    end
                    else
                    begin
                        p_reg <= p_reg + PW'(1);
                    end
                end
                pcss_pkg::S_GAIN:
                begin
                    raw_reg <= mul_p[37:16];
                end
                pcss_pkg::S_LP:
                begin
                    if (lp_sum > 24'sd65535)
                    begin
                        lp_reg <= 17'sd65535;
                    end
                    else if (lp_sum < -24'sd65536)
                    begin
                        lp_reg <= -17'sd65536;
                    end
                    else
                    begin
                        lp_reg <= lp_sum[16:0];
                    end
                    busy_reg <= busy_cnt;
                end
                pcss_pkg::S_PUSH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg <= {3'b0, busy_reg, lp_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== design/pcss_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== design/pcss_mul.sv =====
// Shared signed multiplier used for every product of a tick.
// No dependencies.
module pcss_mul (
    input  logic signed [25:0] a,
    input  logic signed [17:0] b,
    output logic signed [43:0] p
);

    assign p = 44'(a) * 44'(b);

endmodule
